@@ design/obd_pkg.sv @@
package obd_pkg;

    localparam int CODE_W    = 8;
    localparam int COORD_W   = 5;
    localparam int BLK_W     = 3;
    localparam int VAL_W     = 8;
    localparam int CHILD_W   = 3;
    localparam int CFG_SIZE_W = 3;
    localparam int BITS_W    = 4;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CHILD_W-1:0] CHILD_LAST = 3'd7;

    localparam logic [1:0] REG_TREE_SIZE  = 2'd0;
    localparam logic [1:0] REG_HIGH_VALUE = 2'd1;
    localparam logic [1:0] REG_LOW_VALUE  = 2'd2;

    localparam logic [CFG_SIZE_W-1:0] TREE_SIZE_RST  = 3'd3;
    localparam logic [VAL_W-1:0]      HIGH_VALUE_RST = 8'd255;
    localparam logic [VAL_W-1:0]      LOW_VALUE_RST  = 8'd0;

    typedef struct packed {
        logic               is_leaf;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] origin_z;
        logic [BLK_W-1:0]   block_log2;
        logic [VAL_W-1:0]   fill_value;
        logic               tree_end;
    } leaf_t;

endpackage

@@ design/obd_walk.sv @@
module obd_walk import obd_pkg::*; #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic                  code_bit,
    input  logic [CFG_SIZE_W-1:0] tree_size_log2,
    input  logic [VAL_W-1:0]      high_value,
    input  logic [VAL_W-1:0]      low_value,
    output leaf_t                 leaf
);

    localparam int LVL_W = $clog2(MAX_LEVELS + 1);
    localparam int ORG_W = (MAX_LEVELS > COORD_W) ? MAX_LEVELS : COORD_W;

    logic [CHILD_W-1:0] child_stack_reg  [MAX_LEVELS];
    logic [CHILD_W-1:0] child_stack_next [MAX_LEVELS];
    logic [LVL_W-1:0]   depth_reg, depth_next;
    logic               awaiting_reg, awaiting_next;

    logic [LVL_W-1:0]   lvls;
    logic               size_zero;
    logic               found;
    logic [LVL_W-1:0]   sel;
    logic [ORG_W-1:0]   org_x, org_y, org_z;

    assign lvls = (int'(tree_size_log2) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS)
                                                       : LVL_W'(tree_size_log2);
    assign size_zero = (depth_reg >= lvls);

    always_comb begin
        org_x = '0;
        org_y = '0;
        org_z = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            for (int p = 0; p < MAX_LEVELS; p++) begin
                if (i < int'(depth_reg) && i < int'(lvls) && p == int'(lvls) - 1 - i) begin
                    org_x[p] = child_stack_reg[i][0];
                    org_y[p] = child_stack_reg[i][1];
                    org_z[p] = child_stack_reg[i][2];
                end
            end
        end
    end

    // find the deepest open level that still has a sibling to visit
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int d = 0; d < MAX_LEVELS; d++) begin
            if (d < int'(depth_reg) && child_stack_reg[d] != CHILD_LAST) begin
                found = 1'b1;
                sel   = LVL_W'(d);
            end
        end
    end

    always_comb begin
        leaf.is_leaf    = awaiting_reg || size_zero;
        leaf.origin_x   = org_x[COORD_W-1:0];
        leaf.origin_y   = org_y[COORD_W-1:0];
        leaf.origin_z   = org_z[COORD_W-1:0];
        leaf.block_log2 = size_zero ? '0 : BLK_W'(lvls - depth_reg);
        leaf.fill_value = code_bit ? high_value : low_value;
        leaf.tree_end   = !found;
    end

    always_comb begin
        child_stack_next = child_stack_reg;
        depth_next       = depth_reg;
        awaiting_next    = awaiting_reg;
        if (leaf.is_leaf) begin
            awaiting_next = 1'b0;
            if (found) begin
                for (int i = 0; i < MAX_LEVELS; i++) begin
                    if (i == int'(sel)) begin
                        child_stack_next[i] = child_stack_reg[i] + CHILD_W'(1);
                    end
                end
                depth_next = sel + LVL_W'(1);
            end else begin
                depth_next = '0;
            end
        end else if (!code_bit) begin
            awaiting_next = 1'b1;
        end else if (int'(depth_reg) < MAX_LEVELS) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                if (i == int'(depth_reg)) begin
                    child_stack_next[i] = '0;
                end
            end
            depth_next = depth_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                child_stack_reg[i] <= '0;
            end
            depth_reg    <= '0;
            awaiting_reg <= 1'b0;
        end else if (step_en) begin
            child_stack_reg <= child_stack_next;
            depth_reg       <= depth_next;
            awaiting_reg    <= awaiting_next;
        end
    end

endmodule

@@ design/octree_bitstream_decoder.sv @@
// Octree bitstream decoder.
// Input channel (s_valid/s_ready/s_code_byte) takes packed code bytes, MSB first.
// Result channel (m_valid/m_ready/m_*) gives one fill command per leaf: block
// corner, block_log2, fill_value, tree_end on the leaf that closes a tree, and
// last on the final result of a byte. A byte may give zero to eight results.
// APB port: tree_size_log2 at 0x0, high_value at 0x4, low_value at 0x8.
// Write only while idle.
// The tree walker consumes one code bit per cycle from a byte shift register
// while no leaf is held back by a stalled receiver, and drops the rest of a
// byte when a tree ends inside it; the next byte is accepted after the last bit.
// A leaf waits in a holding stage until the next leaf or the end of the byte
// settles its last flag, then moves to the output register.
// When the receiver stalls, the walker halts at the next leaf that finds both
// stages full; bits without a leaf keep going.
// Reset (aresetn, synchronous) clears the walk to the tree root, empties all
// stages and restores the register defaults.
module octree_bitstream_decoder import obd_pkg::*; #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CODE_W-1:0]     s_code_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_W-1:0]    m_origin_x,
    output logic [COORD_W-1:0]    m_origin_y,
    output logic [COORD_W-1:0]    m_origin_z,
    output logic [BLK_W-1:0]      m_block_log2,
    output logic [VAL_W-1:0]      m_fill_value,
    output logic                  m_tree_end,
    output logic                  m_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_SIZE_W-1:0] tree_size_log2_reg;
    logic [VAL_W-1:0]      high_value_reg;
    logic [VAL_W-1:0]      low_value_reg;

    logic [CODE_W-1:0]     shift_reg;
    logic [BITS_W-1:0]     bits_left_reg;
    logic                  pend_valid_reg;
    leaf_t                 pend_reg;
    logic                  m_valid_reg;
    leaf_t                 out_reg;
    logic                  m_last_reg;

    leaf_t                 leaf;
    logic                  cfg_wr;
    logic                  out_free;
    logic                  step_ok;
    logic                  take_leaf;
    logic                  flush;
    logic                  push_out;

    obd_walk #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_ok),
        .code_bit      (shift_reg[CODE_W-1]),
        .tree_size_log2(tree_size_log2_reg),
        .high_value    (high_value_reg),
        .low_value     (low_value_reg),
        .leaf          (leaf)
    );

    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign step_ok   = (bits_left_reg != '0) && (!leaf.is_leaf || !pend_valid_reg || out_free);
    assign take_leaf = step_ok && leaf.is_leaf;
    assign flush     = pend_valid_reg && (bits_left_reg == '0) && out_free;
    assign push_out  = (take_leaf && pend_valid_reg) || flush;
    assign s_ready   = (bits_left_reg == '0) && (!pend_valid_reg || out_free);

    always_comb begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_TREE_SIZE:  prdata = APB_DATA_W'(tree_size_log2_reg);
            REG_HIGH_VALUE: prdata = APB_DATA_W'(high_value_reg);
            REG_LOW_VALUE:  prdata = APB_DATA_W'(low_value_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tree_size_log2_reg <= TREE_SIZE_RST;
            high_value_reg     <= HIGH_VALUE_RST;
            low_value_reg      <= LOW_VALUE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[APB_ADDR_W-1:2])
                REG_TREE_SIZE:  tree_size_log2_reg <= pwdata[CFG_SIZE_W-1:0];
                REG_HIGH_VALUE: high_value_reg     <= pwdata[VAL_W-1:0];
                REG_LOW_VALUE:  low_value_reg      <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_left_reg  <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bits_left_reg <= BITS_W'(CODE_W);
            end else if (step_ok) begin
                // drop the rest of the byte once the tree is done
                if (leaf.is_leaf && leaf.tree_end) begin
                    bits_left_reg <= '0;
                end else begin
                    bits_left_reg <= bits_left_reg - BITS_W'(1);
                end
            end
            if (take_leaf) begin
                pend_valid_reg <= 1'b1;
            end else if (flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            shift_reg <= s_code_byte;
        end else if (step_ok) begin
            shift_reg <= {shift_reg[CODE_W-2:0], 1'b0};
        end
        if (take_leaf) begin
            pend_reg <= leaf;
        end
        if (push_out) begin
            out_reg    <= pend_reg;
            m_last_reg <= flush;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_origin_x   = out_reg.origin_x;
    assign m_origin_y   = out_reg.origin_y;
    assign m_origin_z   = out_reg.origin_z;
    assign m_block_log2 = out_reg.block_log2;
    assign m_fill_value = out_reg.fill_value;
    assign m_tree_end   = out_reg.tree_end;
    assign m_last       = m_last_reg;

    a_tree_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.tree_end |-> m_last_reg)
        else $error("tree end result without last");

    a_tree_end_drops_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        take_leaf && leaf.tree_end |=> bits_left_reg == '0)
        else $error("bits left after tree end");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        flush |=> m_valid_reg && m_last_reg && !pend_valid_reg)
        else $error("held leaf not flushed as last item");

endmodule

@@ dv/obd_fill_checker.sv @@
`timescale 1ns / 100ps
module obd_fill_checker import obd_pkg::*; #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [CODE_W-1:0]     s_code_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [COORD_W-1:0]    m_origin_x,
    input  logic [COORD_W-1:0]    m_origin_y,
    input  logic [COORD_W-1:0]    m_origin_z,
    input  logic [BLK_W-1:0]      m_block_log2,
    input  logic [VAL_W-1:0]      m_fill_value,
    input  logic                  m_tree_end,
    input  logic                  m_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] origin_z;
        logic [BLK_W-1:0]   block_log2;
        logic [VAL_W-1:0]   fill_value;
        logic               tree_end;
        logic               last;
    } fill_t;

    logic [CHILD_W-1:0]    walk_path [MAX_LEVELS];
    int unsigned           walk_depth;
    logic                  colour_next;
    logic [CFG_SIZE_W-1:0] tree_size;
    logic [VAL_W-1:0]      high_value;
    logic [VAL_W-1:0]      low_value;
    fill_t                 fills_due [$];
    fill_t                 want;
    int                    errors = 0;

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    function automatic void decode_code_byte(input logic [CODE_W-1:0] code);
        fill_t       leaves [8];
        int          count;
        int          i;
        int unsigned k;
        int unsigned lv;
        int unsigned size;
        int unsigned ox;
        int unsigned oy;
        int unsigned oz;
        logic        done;
        lv = (tree_size > MAX_LEVELS) ? MAX_LEVELS : tree_size;
        count = 0;
        for (i = CODE_W - 1; i >= 0; i--) begin
            size = (walk_depth >= lv) ? 0 : lv - walk_depth;
            if (colour_next || size == 0) begin
                ox = 0;
                oy = 0;
                oz = 0;
                for (k = 0; k < walk_depth && k < MAX_LEVELS && k < lv; k++) begin
                    ox = ox | ({31'd0, walk_path[k][0]} << (lv - 1 - k));
                    oy = oy | ({31'd0, walk_path[k][1]} << (lv - 1 - k));
                    oz = oz | ({31'd0, walk_path[k][2]} << (lv - 1 - k));
                end
                leaves[count].origin_x   = ox[COORD_W-1:0];
                leaves[count].origin_y   = oy[COORD_W-1:0];
                leaves[count].origin_z   = oz[COORD_W-1:0];
                leaves[count].block_log2 = size[BLK_W-1:0];
                leaves[count].fill_value = code[i] ? high_value : low_value;
                leaves[count].tree_end   = 1'b0;
                leaves[count].last       = 1'b0;
                colour_next = 1'b0;
                count++;
                done = 1'b1;
                while (walk_depth > 0) begin
                    if (walk_path[walk_depth-1] != CHILD_LAST) begin
                        walk_path[walk_depth-1] = walk_path[walk_depth-1] + 1'b1;
                        done = 1'b0;
                        break;
                    end
                    walk_depth--;
                end
                if (done) begin
                    leaves[count-1].tree_end = 1'b1;
                    break;
                end
            end else if (!code[i]) begin
                colour_next = 1'b1;
            end else if (walk_depth < MAX_LEVELS) begin
                walk_path[walk_depth] = '0;
                walk_depth++;
            end
        end
        if (count > 0) leaves[count-1].last = 1'b1;
        for (i = 0; i < count; i++) fills_due.push_back(leaves[i]);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_LEVELS; j++) walk_path[j] = '0;
            walk_depth  = 0;
            colour_next = 1'b0;
            tree_size   = TREE_SIZE_RST;
            high_value  = HIGH_VALUE_RST;
            low_value   = LOW_VALUE_RST;
            fills_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (fills_due.size() == 0) begin
                    $error("fill item with none expected: origin %0d,%0d,%0d",
                           m_origin_x, m_origin_y, m_origin_z);
                    errors++;
                end else begin
                    want = fills_due.pop_front();
                    check_field("origin_x", want.origin_x, m_origin_x);
                    check_field("origin_y", want.origin_y, m_origin_y);
                    check_field("origin_z", want.origin_z, m_origin_z);
                    check_field("block_log2", want.block_log2, m_block_log2);
                    check_field("fill_value", want.fill_value, m_fill_value);
                    check_field("tree_end", want.tree_end, m_tree_end);
                    check_field("last", want.last, m_last);
                end
            end
            if (s_valid && s_ready) decode_code_byte(s_code_byte);
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_TREE_SIZE: begin
                        tree_size = pwdata[CFG_SIZE_W-1:0];
                    end
                    REG_HIGH_VALUE: begin
                        high_value = pwdata[VAL_W-1:0];
                    end
                    REG_LOW_VALUE: begin
                        low_value = pwdata[VAL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        fail_count  <= errors;
        outstanding <= fills_due.size();
    end

endmodule

@@ dv/tb_octree_bitstream_decoder.sv @@
`timescale 1ns / 100ps
module tb_octree_bitstream_decoder;
    import obd_pkg::*;

    localparam int LEVELS        = 5;
    localparam int PHASES        = 10;
    localparam int PHASE_BYTES   = 43;
    localparam int QUIET_TAIL    = 40;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam logic [3*PHASES-1:0] PHASE_SIZES =
        {3'd3, 3'd7, 3'd2, 3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd4, 3'd1};

    typedef enum logic [1:0] {SHAPE_TREE, SHAPE_NOISE, SHAPE_FIXED} shape_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CODE_W-1:0]     s_code_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COORD_W-1:0]    m_origin_x;
    logic [COORD_W-1:0]    m_origin_y;
    logic [COORD_W-1:0]    m_origin_z;
    logic [BLK_W-1:0]      m_block_log2;
    logic [VAL_W-1:0]      m_fill_value;
    logic                  m_tree_end;
    logic                  m_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    outstanding;

    logic                  hold_req = 1'b0;
    logic                  quiet = 1'b0;
    logic [CFG_SIZE_W-1:0] cfg_size = TREE_SIZE_RST;
    logic [CHILD_W-1:0]    gen_path [LEVELS];
    int unsigned           gen_depth = 0;
    logic                  gen_colour = 1'b0;

    octree_bitstream_decoder #(.MAX_LEVELS(LEVELS)) dut (.*);
    obd_fill_checker #(.MAX_LEVELS(LEVELS)) u_checker (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned gen_size();
        int unsigned lv;
        lv = (cfg_size > LEVELS) ? LEVELS : cfg_size;
        return (gen_depth >= lv) ? 0 : lv - gen_depth;
    endfunction

    function automatic logic walk_bit(input logic b);
        if (gen_colour || gen_size() == 0) begin
            gen_colour = 1'b0;
            while (gen_depth > 0) begin
                if (gen_path[gen_depth-1] != CHILD_LAST) begin
                    gen_path[gen_depth-1] = gen_path[gen_depth-1] + 1'b1;
                    return 1'b0;
                end
                gen_depth--;
            end
            return 1'b1;
        end
        if (!b) begin
            gen_colour = 1'b1;
        end else if (gen_depth < LEVELS) begin
            gen_path[gen_depth] = '0;
            gen_depth++;
        end
        return 1'b0;
    endfunction

    function automatic logic pick_bit();
        if (gen_colour || gen_size() == 0) return 1'($urandom_range(1));
        if (gen_depth == 0) return $urandom_range(99) < 70;
        return $urandom_range(99) < 15;
    endfunction

    function automatic logic [CODE_W-1:0] next_code(input shape_t shape,
                                                    input logic [CODE_W-1:0] given);
        logic [CODE_W-1:0] code;
        logic              ended;
        int                i;
        code = (shape == SHAPE_FIXED) ? given : CODE_W'($urandom);
        ended = 1'b0;
        for (i = CODE_W - 1; i >= 0; i--) begin
            if (!ended) begin
                if (shape == SHAPE_TREE) code[i] = pick_bit();
                ended = walk_bit(code[i]);
            end
        end
        return code;
    endfunction

    task automatic send_code(input shape_t shape, input logic [CODE_W-1:0] given,
                             input logic may_idle);
        if (may_idle && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_code_byte <= next_code(shape, given);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_TREE_SIZE) cfg_size = value[CFG_SIZE_W-1:0];
        @(posedge aclk);
    endtask

    task automatic finish_tree();
        while (gen_depth != 0 || gen_colour) send_code(SHAPE_TREE, '0, 1'b1);
    endtask

    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(16, 1)) @(posedge aclk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int p;
        int k;
        int n;
        for (p = 0; p < LEVELS; p++) gen_path[p] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_code(SHAPE_FIXED, 8'h00, 1'b0);
        send_code(SHAPE_FIXED, 8'h7F, 1'b0);
        send_code(SHAPE_FIXED, 8'hFF, 1'b0);
        drain();
        // shrink the tree while deep inside it
        write_reg(REG_TREE_SIZE, 32'd2);
        send_code(SHAPE_FIXED, 8'h00, 1'b0);
        finish_tree();
        // three colour pairs, then a split whose eight children fill one byte
        send_code(SHAPE_FIXED, 8'hA3, 1'b0);
        send_code(SHAPE_FIXED, 8'h5A, 1'b0);
        send_code(SHAPE_FIXED, 8'h44, 1'b0);
        drain();
        write_reg(REG_TREE_SIZE, 32'd0);
        write_reg(REG_HIGH_VALUE, 32'd0);
        write_reg(REG_LOW_VALUE, 32'd255);
        send_code(SHAPE_FIXED, 8'hFF, 1'b0);
        send_code(SHAPE_FIXED, 8'h00, 1'b0);
        send_code(SHAPE_FIXED, 8'h80, 1'b0);
        drain();
        write_reg(REG_TREE_SIZE, 32'd7);
        send_code(SHAPE_FIXED, 8'hFF, 1'b0);
        send_code(SHAPE_FIXED, 8'hFF, 1'b0);

        for (p = 0; p < PHASES; p++) begin
            drain();
            write_reg(REG_TREE_SIZE, {29'd0, PHASE_SIZES[3*p +: 3]});
            write_reg(REG_HIGH_VALUE, $urandom_range(255));
            write_reg(REG_LOW_VALUE, $urandom_range(255));
            for (k = 0; k < PHASE_BYTES; k++) begin
                n = p * PHASE_BYTES + k;
                if (n == 20) hold_req = 1'b1;
                if (n == 70) drain();
                if (n == PHASES * PHASE_BYTES - QUIET_TAIL) quiet = 1'b1;
                send_code(($urandom_range(4) == 0) ? SHAPE_NOISE : SHAPE_TREE, '0, !quiet);
            end
        end

        drain();
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
